// ===== rtl/rmc_pkg.sv =====
`timescale 1ns / 1ps
// RMC sentence parser: shared constants, types and helper functions.
// No dependencies; every other file imports this package.
package rmc_pkg;

  localparam int LINE_BYTES  = 128;
  localparam int MAX_FIELDS  = 15;
  localparam int FRAC_DIGITS = 5;
  localparam int MIN_FIELDS  = 8;
  localparam int HDR_LEN     = 6;

  function automatic longint unsigned pow10(input int n);
    longint unsigned v;
    int i;
    v = 64'd1;
    for (i = 0; i < n; i++) begin
      v = v * 64'd10;
    end
    return v;
  endfunction

  localparam int POS_W       = $clog2(LINE_BYTES + 1);
  localparam int FNUM_W      = $clog2(MAX_FIELDS + 1);
  localparam int INT_W       = 17;
  localparam int FRAC_W      = $clog2(pow10(FRAC_DIGITS));
  localparam int FCNT_W      = $clog2(FRAC_DIGITS + 1);
  localparam int MILLI_DIGITS = 3;
  localparam int MILLI_W     = 10;
  localparam int MILLI_WT_W  = 7;
  localparam int DEG_W       = 11;
  localparam int MM_W        = 7;
  localparam int E7_W        = 24;
  localparam int ANG_MAG_W   = 34;
  localparam int ANG_W       = 35;
  localparam int X_W         = 30;
  localparam int Y_W         = 28;
  localparam int PART_W      = 24;
  localparam int SPEED_W     = 27;
  localparam int DIV100_SHIFT = 24;
  localparam int DIV100_MUL_W = 18;

  localparam logic [INT_W-1:0]     INT_SAT   = 17'd131071;
  localparam logic [ANG_MAG_W-1:0] ANGLE_SAT = 34'd10100000000;
  localparam logic [SPEED_W-1:0]   SPEED_SAT = 27'd99999999;
  localparam logic [E7_W-1:0]      E7        = 24'd10000000;
  localparam longint unsigned      FRAC_TO_E7 = pow10(7 - FRAC_DIGITS);
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL =
    DIV100_MUL_W'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);
  localparam logic [31:0] DIV15_MUL = 32'(((64'd1 << 32) - 64'd1) / 64'd15);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;

  localparam logic [FNUM_W-1:0] SLOT_IDLE   = FNUM_W'(0);
  localparam logic [FNUM_W-1:0] SLOT_STATUS = FNUM_W'(2);
  localparam logic [FNUM_W-1:0] SLOT_LAT    = FNUM_W'(3);
  localparam logic [FNUM_W-1:0] SLOT_NS     = FNUM_W'(4);
  localparam logic [FNUM_W-1:0] SLOT_LON    = FNUM_W'(5);
  localparam logic [FNUM_W-1:0] SLOT_EW     = FNUM_W'(6);
  localparam logic [FNUM_W-1:0] SLOT_SPEED  = FNUM_W'(7);

  typedef enum logic [1:0] {
    ST_FIX        = 2'd0,
    ST_VOID       = 2'd1,
    ST_BAD_HEADER = 2'd2,
    ST_FEW_FIELDS = 2'd3
  } rmc_status_t;

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_INT  = 2'd1,
    PH_FRAC = 2'd2,
    PH_DONE = 2'd3
  } rmc_phase_t;

  typedef struct packed {
    rmc_status_t          status;
    logic [INT_W-1:0]     lat_int;
    logic [FRAC_W-1:0]    lat_frac;
    logic                 south;
    logic [INT_W-1:0]     lon_int;
    logic [FRAC_W-1:0]    lon_frac;
    logic                 west;
    logic [INT_W-1:0]     spd_int;
    logic [MILLI_W-1:0]   spd_milli;
  } rmc_rec_t;

  typedef struct packed {
    logic s_deg;
    logic s_mm;
    logic s_scale;
    logic s_recip;
    logic s_total;
  } rmc_stage_en_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h4D;
      3'd5:    ch = 8'h43;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // weight of a fraction digit, scaled to FRAC_DIGITS places
  function automatic logic [FRAC_W-1:0] frac_weight(input logic [FCNT_W-1:0] pos);
    logic [FRAC_W-1:0] w;
    int k;
    w = '0;
    for (k = 0; k < FRAC_DIGITS; k++) begin
      if (pos == FCNT_W'(k)) begin
        w = FRAC_W'(pow10(FRAC_DIGITS - 1 - k));
      end
    end
    return w;
  endfunction

  // weight of a fraction digit in thousandths
  function automatic logic [MILLI_WT_W-1:0] milli_weight(input logic [FCNT_W-1:0] pos);
    logic [MILLI_WT_W-1:0] w;
    int k;
    w = '0;
    for (k = 0; k < MILLI_DIGITS; k++) begin
      if (pos == FCNT_W'(k)) begin
        w = MILLI_WT_W'(pow10(MILLI_DIGITS - 1 - k));
      end
    end
    return w;
  endfunction

endpackage

// ===== rtl/rmc_if.sv =====
`timescale 1ns / 1ps
// RMC sentence parser: valid/ready channel interfaces for bytes and results.
// Depends on rmc_pkg for field widths.
interface rmc_in_if import rmc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface rmc_out_if import rmc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                parse_status;
  logic                      fix_flag;
  logic signed [ANG_W-1:0]   latitude_e7;
  logic signed [ANG_W-1:0]   longitude_e7;
  logic [SPEED_W-1:0]        speed_milliknots;

  modport source (output valid, output parse_status, output fix_flag,
                  output latitude_e7, output longitude_e7, output speed_milliknots,
                  input ready);
  modport sink   (input valid, input parse_status, input fix_flag,
                  input latitude_e7, input longitude_e7, input speed_milliknots,
                  output ready);
endinterface

// ===== rtl/nmea_rmc_sentence_parser_core.sv =====
`timescale 1ns / 1ps
// RMC sentence parser top level: byte parser feeding the result pipeline.
// Result path: after the final byte is taken, the record register, the result stages and
// the output register lie before the result is valid. Throughput: one byte per cycle; bytes
// stall only while a finished sentence waits in front of full result stages and the output
// word is not taken. Reset (rst_n low, synchronous) empties the pipeline, clears the
// sentence state and zeroes the held fix, position and speed.
module nmea_rmc_sentence_parser_core import rmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rmc_in_if.sink    in_ch,
  rmc_out_if.source out_ch
);

  logic     rec_valid;
  logic     rec_ready;
  rmc_rec_t rec;

  rmc_field_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_ready (rec_ready)
  );

  rmc_convert u_convert (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_ready (rec_ready),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/rmc_field_parser.sv =====
`timescale 1ns / 1ps
// RMC sentence parser: per-byte header check, field split and number scan.
// Depends on rmc_pkg and rmc_in_if; emits one sentence record per final byte.
module rmc_field_parser import rmc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  rmc_in_if.sink   in_ch,
  output logic     rec_valid,
  output rmc_rec_t rec,
  input  logic     rec_ready
);

  localparam logic [1:0] CNT_MANY = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0]   byte_pos;
    logic               hdr_ok;
    logic [FNUM_W-1:0]  field_num;
    logic               field_open;
    logic [FNUM_W-1:0]  field_slot;
    logic [1:0]         char_cnt;
    logic [7:0]         first_char;
    logic [INT_W-1:0]   int_acc;
    logic [FRAC_W-1:0]  frac_acc;
    logic [MILLI_W-1:0] milli_acc;
    logic [FCNT_W-1:0]  frac_cnt;
    rmc_phase_t         phase;
    logic               active;
    logic               south;
    logic               west;
    logic [INT_W-1:0]   lat_int;
    logic [FRAC_W-1:0]  lat_frac;
    logic [INT_W-1:0]   lon_int;
    logic [FRAC_W-1:0]  lon_frac;
    logic [INT_W-1:0]   spd_int;
    logic [MILLI_W-1:0] spd_milli;
  } parse_t;

  localparam parse_t PARSE_CLEAR = '{hdr_ok: 1'b1, phase: PH_LEAD, default: '0};

  parse_t   st_r, st_nxt, s;
  rmc_rec_t rec_r, rec_nxt;
  logic     rec_valid_r, rec_valid_nxt;

  logic                byte_acc;
  logic [7:0]          c;
  logic                last;
  logic                in_line;
  logic                split_en;
  logic                is_comma;
  logic                is_digit;
  logic                is_space;
  logic                feed;
  logic                single;
  logic [3:0]          digit_val;
  logic [INT_W+3:0]    int_ten;
  logic [FRAC_W+3:0]   frac_step;
  logic [MILLI_W-1:0]  milli_step;
  rmc_status_t         status;

  assign c        = in_ch.char_in;
  assign last     = in_ch.last_char;
  assign in_ch.ready = !rec_valid_r || rec_ready;
  assign byte_acc = in_ch.valid && in_ch.ready;
  assign digit_val = c[3:0];

  always_comb begin
    s         = st_r;
    rec_nxt   = rec_r;
    in_line   = st_r.byte_pos < POS_W'(LINE_BYTES);
    split_en  = in_line && (c != CH_NUL) && (st_r.byte_pos < POS_W'(LINE_BYTES - 1));
    is_comma  = (c == CH_COMMA);
    is_digit  = (c >= CH_0) && (c <= CH_9);
    is_space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    feed      = split_en && !is_comma;
    status    = ST_FIX;

    if (in_line) begin
      if ((st_r.byte_pos < POS_W'(HDR_LEN)) && (c != hdr_char(st_r.byte_pos[2:0]))) begin
        s.hdr_ok = 1'b0;
      end
      s.byte_pos = (c == CH_NUL) ? POS_W'(LINE_BYTES) : st_r.byte_pos + 1'b1;
    end

    // open a new field
    if (feed && !st_r.field_open) begin
      s.field_open = 1'b1;
      if (st_r.field_num < FNUM_W'(MAX_FIELDS)) begin
        s.field_slot = st_r.field_num;
        s.field_num  = st_r.field_num + 1'b1;
      end else begin
        s.field_slot = SLOT_IDLE;
      end
      s.char_cnt   = '0;
      s.first_char = c;
      s.int_acc    = '0;
      s.frac_acc   = '0;
      s.milli_acc  = '0;
      s.frac_cnt   = '0;
      s.phase      = PH_LEAD;
    end

    int_ten    = ({4'b0000, s.int_acc} << 3) + ({4'b0000, s.int_acc} << 1)
               + (INT_W+4)'(digit_val);
    frac_step  = (FRAC_W+4)'(digit_val) * (FRAC_W+4)'(frac_weight(s.frac_cnt));
    milli_step = MILLI_W'(digit_val) * MILLI_W'(milli_weight(s.frac_cnt));

    if (feed) begin
      s.char_cnt = (s.char_cnt == CNT_MANY) ? CNT_MANY : s.char_cnt + 1'b1;
      case (s.phase)
        PH_LEAD, PH_INT: begin
          if (!((s.phase == PH_LEAD) && is_space)) begin
            if (is_digit) begin
              s.int_acc = (int_ten > (INT_W+4)'(INT_SAT)) ? INT_SAT : int_ten[INT_W-1:0];
              s.phase   = PH_INT;
            end else if (c == CH_DOT) begin
              s.phase = PH_FRAC;
            end else begin
              s.phase = PH_DONE;
            end
          end
        end
        PH_FRAC: begin
          if (is_digit) begin
            if (s.frac_cnt < FCNT_W'(FRAC_DIGITS)) begin
              s.frac_acc  = s.frac_acc + frac_step[FRAC_W-1:0];
              s.milli_acc = s.milli_acc + milli_step;
              s.frac_cnt  = s.frac_cnt + 1'b1;
            end
          end else begin
            s.phase = PH_DONE;
          end
        end
        default: ;
      endcase
    end

    // close the open field
    single = (s.char_cnt == 2'd1);
    if ((split_en && is_comma) || last) begin
      if (s.field_open) begin
        case (s.field_slot)
          SLOT_STATUS: s.active = single && (s.first_char == CH_A);
          SLOT_LAT: begin
            s.lat_int  = s.int_acc;
            s.lat_frac = s.frac_acc;
          end
          SLOT_NS:     s.south = single && (s.first_char == CH_S);
          SLOT_LON: begin
            s.lon_int  = s.int_acc;
            s.lon_frac = s.frac_acc;
          end
          SLOT_EW:     s.west = single && (s.first_char == CH_W);
          SLOT_SPEED: begin
            s.spd_int   = s.int_acc;
            s.spd_milli = s.milli_acc;
          end
          default: ;
        endcase
        s.field_open = 1'b0;
      end
    end

    if (!s.hdr_ok || (s.byte_pos < POS_W'(HDR_LEN))) begin
      status = ST_BAD_HEADER;
    end else if (s.field_num < FNUM_W'(MIN_FIELDS)) begin
      status = ST_FEW_FIELDS;
    end else if (!s.active) begin
      status = ST_VOID;
    end else begin
      status = ST_FIX;
    end

    st_nxt = st_r;
    if (byte_acc) begin
      if (last) begin
        st_nxt            = PARSE_CLEAR;
        rec_nxt.status    = status;
        rec_nxt.lat_int   = s.lat_int;
        rec_nxt.lat_frac  = s.lat_frac;
        rec_nxt.south     = s.south;
        rec_nxt.lon_int   = s.lon_int;
        rec_nxt.lon_frac  = s.lon_frac;
        rec_nxt.west      = s.west;
        rec_nxt.spd_int   = s.spd_int;
        rec_nxt.spd_milli = s.spd_milli;
      end else begin
        st_nxt = s;
      end
    end
  end

  always_comb begin
    if (byte_acc && last) begin
      rec_valid_nxt = 1'b1;
    end else if (rec_ready) begin
      rec_valid_nxt = 1'b0;
    end else begin
      rec_valid_nxt = rec_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= PARSE_CLEAR;
      rec_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rec_valid_r <= rec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

endmodule

// ===== rtl/rmc_angle_lane.sv =====
`timescale 1ns / 1ps
// RMC sentence parser: DDMM.mmmmm to 1e-7 degree conversion, five stages.
// Depends on rmc_pkg; stage loads come from the converter's flow control.
module rmc_angle_lane import rmc_pkg::*; (
  input  logic                 clk,
  input  rmc_stage_en_t        en,
  input  logic [INT_W-1:0]     int_in,
  input  logic [FRAC_W-1:0]    frac_in,
  input  logic                 neg_in,
  output logic [ANG_MAG_W-1:0] mag,
  output logic                 neg
);

  logic [INT_W+DIV100_MUL_W-1:0] deg_prod;
  logic [DEG_W-1:0]              deg_r;
  logic [INT_W-1:0]              int_b_r;
  logic [FRAC_W-1:0]             frac_b_r;
  logic                          neg_b_r;

  logic [INT_W-1:0]              mm_full;
  logic [MM_W-1:0]               mm_r;
  logic [ANG_MAG_W-1:0]          deg_e7_c_r;
  logic [FRAC_W-1:0]             frac_c_r;
  logic                          neg_c_r;

  logic [X_W-1:0]                x_val;
  logic [Y_W-1:0]                y_d_r;
  logic [ANG_MAG_W-1:0]          deg_e7_d_r;
  logic                          neg_d_r;

  logic [Y_W+31:0]               q_prod;
  logic [PART_W-1:0]             q_r;
  logic [Y_W-1:0]                y_e_r;
  logic [ANG_MAG_W-1:0]          deg_e7_e_r;
  logic                          neg_e_r;

  logic [Y_W-1:0]                rem;
  logic [PART_W-1:0]             part;
  logic [ANG_MAG_W-1:0]          total;
  logic [ANG_MAG_W-1:0]          mag_r;
  logic                          neg_f_r;

  assign deg_prod = (INT_W+DIV100_MUL_W)'(int_in) * (INT_W+DIV100_MUL_W)'(DIV100_MUL);
  assign mm_full  = int_b_r - INT_W'(deg_r) * INT_W'(100);
  assign x_val    = X_W'(mm_r) * X_W'(E7) + X_W'(frac_c_r) * X_W'(FRAC_TO_E7);
  assign q_prod   = (Y_W+32)'(y_d_r) * (Y_W+32)'(DIV15_MUL);
  assign rem      = y_e_r - Y_W'(q_r) * Y_W'(15);
  assign part     = (rem >= Y_W'(15)) ? q_r + 1'b1 : q_r;
  assign total    = deg_e7_e_r + ANG_MAG_W'(part);

  always_ff @(posedge clk) begin
    if (en.s_deg) begin
      deg_r    <= deg_prod[DIV100_SHIFT +: DEG_W];
      int_b_r  <= int_in;
      frac_b_r <= frac_in;
      neg_b_r  <= neg_in;
    end
    if (en.s_mm) begin
      mm_r       <= mm_full[MM_W-1:0];
      deg_e7_c_r <= ANG_MAG_W'(deg_r) * ANG_MAG_W'(E7);
      frac_c_r   <= frac_b_r;
      neg_c_r    <= neg_b_r;
    end
    if (en.s_scale) begin
      y_d_r      <= x_val[X_W-1:2];
      deg_e7_d_r <= deg_e7_c_r;
      neg_d_r    <= neg_c_r;
    end
    if (en.s_recip) begin
      q_r        <= q_prod[32 +: PART_W];
      y_e_r      <= y_d_r;
      deg_e7_e_r <= deg_e7_d_r;
      neg_e_r    <= neg_d_r;
    end
    if (en.s_total) begin
      mag_r   <= (total > ANGLE_SAT) ? ANGLE_SAT : total;
      neg_f_r <= neg_e_r;
    end
  end

  assign mag = mag_r;
  assign neg = neg_f_r;

endmodule

// ===== rtl/rmc_convert.sv =====
`timescale 1ns / 1ps
// RMC sentence parser: result pipeline, held fix values and output register.
// Depends on rmc_pkg, rmc_out_if and rmc_angle_lane.
module rmc_convert import rmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rec_valid,
  input  rmc_rec_t    rec,
  output logic        rec_ready,
  rmc_out_if.source   out_ch
);

  localparam int SIDE_STAGES = 5;

  typedef struct packed {
    rmc_status_t        status;
    logic [SPEED_W-1:0] speed;
  } side_t;

  logic vb_r, vc_r, vd_r, ve_r, vf_r, vo_r;
  logic rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_o;
  logic [SIDE_STAGES-1:0] ld;
  rmc_stage_en_t en;

  side_t side_r [SIDE_STAGES];
  logic [SPEED_W:0]       spd_full;
  logic [SPEED_W-1:0]     spd_sat;

  logic [ANG_MAG_W-1:0]   lat_mag, lon_mag;
  logic                   lat_neg, lon_neg;
  logic [ANG_W-1:0]       lat_ext, lon_ext;
  logic [ANG_W-1:0]       lat_val, lon_val;

  logic                   held_fix_r;
  logic signed [ANG_W-1:0] held_lat_r, held_lon_r;
  logic [SPEED_W-1:0]     held_spd_r;
  rmc_status_t            out_status_r;

  // hold a stage while it and everything below it are full and the output is not taken
  assign rdy_o = !vo_r || out_ch.ready;
  assign rdy_f = !vf_r || rdy_o;
  assign rdy_e = !ve_r || rdy_f;
  assign rdy_d = !vd_r || rdy_e;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rec_ready = rdy_b;

  assign ld = {rdy_f, rdy_e, rdy_d, rdy_c, rdy_b};
  assign en = '{s_deg: rdy_b, s_mm: rdy_c, s_scale: rdy_d, s_recip: rdy_e, s_total: rdy_f};

  rmc_angle_lane u_lat (
    .clk     (clk),
    .en      (en),
    .int_in  (rec.lat_int),
    .frac_in (rec.lat_frac),
    .neg_in  (rec.south),
    .mag     (lat_mag),
    .neg     (lat_neg)
  );

  rmc_angle_lane u_lon (
    .clk     (clk),
    .en      (en),
    .int_in  (rec.lon_int),
    .frac_in (rec.lon_frac),
    .neg_in  (rec.west),
    .mag     (lon_mag),
    .neg     (lon_neg)
  );

  assign spd_full = (SPEED_W+1)'(rec.spd_int) * (SPEED_W+1)'(1000)
                  + (SPEED_W+1)'(rec.spd_milli);
  assign spd_sat  = (spd_full > (SPEED_W+1)'(SPEED_SAT)) ? SPEED_SAT : spd_full[SPEED_W-1:0];

  assign lat_ext = {1'b0, lat_mag};
  assign lon_ext = {1'b0, lon_mag};
  assign lat_val = lat_neg ? (ANG_W'(0) - lat_ext) : lat_ext;
  assign lon_val = lon_neg ? (ANG_W'(0) - lon_ext) : lon_ext;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      side_r[0].status <= rec.status;
      side_r[0].speed  <= spd_sat;
    end
    for (int k = 1; k < SIDE_STAGES; k++) begin
      if (ld[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
    if (rdy_o) begin
      out_status_r <= side_r[SIDE_STAGES-1].status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r       <= 1'b0;
      vc_r       <= 1'b0;
      vd_r       <= 1'b0;
      ve_r       <= 1'b0;
      vf_r       <= 1'b0;
      vo_r       <= 1'b0;
      held_fix_r <= 1'b0;
      held_lat_r <= '0;
      held_lon_r <= '0;
      held_spd_r <= '0;
    end else begin
      if (rdy_b) vb_r <= rec_valid;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
      if (rdy_e) ve_r <= vd_r;
      if (rdy_f) vf_r <= ve_r;
      if (rdy_o) vo_r <= vf_r;
      if (rdy_o && vf_r) begin
        case (side_r[SIDE_STAGES-1].status)
          ST_FIX: begin
            held_fix_r <= 1'b1;
            held_lat_r <= $signed(lat_val);
            held_lon_r <= $signed(lon_val);
            held_spd_r <= side_r[SIDE_STAGES-1].speed;
          end
          ST_VOID: held_fix_r <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  assign out_ch.valid            = vo_r;
  assign out_ch.parse_status     = out_status_r;
  assign out_ch.fix_flag         = held_fix_r;
  assign out_ch.latitude_e7      = held_lat_r;
  assign out_ch.longitude_e7     = held_lon_r;
  assign out_ch.speed_milliknots = held_spd_r;

endmodule
